// ===== rtl/core/blh_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// blh_pkg: shared types and constants for the heartbeat led driver
// Holds the control store of the sequencer, its field codes and the
// register map of the csr port.
// ----------------------------------------------------------------------------
package blh_pkg;

   // register map: word index taken from paddr[2]
   localparam int  CSR_ADDR_W        = 3;
   localparam logic REG_BEAT_TICKS   = 1'b0;
   localparam logic REG_TICKS_PER_S  = 1'b1;
   localparam logic [15:0] BEAT_TICKS_RESET = 16'd2000;
   localparam logic [15:0] TICKS_PER_S_RESET = 16'd1000;

   // pattern phases
   typedef logic [1:0] phase_type;
   localparam phase_type PHASE_WAIT = 2'd0;
   localparam phase_type PHASE_RISE = 2'd1;
   localparam phase_type PHASE_HOLD = 2'd2;
   localparam phase_type PHASE_FALL = 2'd3;

   // sequencer step addresses
   typedef logic [2:0] upc_type;
   localparam upc_type UPC_FETCH     = 3'd0;
   localparam upc_type UPC_CHK_START = 3'd1;
   localparam upc_type UPC_SQ_INIT   = 3'd2;
   localparam upc_type UPC_SQ_ITER   = 3'd3;
   localparam upc_type UPC_CHK_TL    = 3'd4;
   localparam upc_type UPC_ADV       = 3'd5;
   localparam upc_type UPC_LOAD      = 3'd6;
   localparam upc_type UPC_EMIT      = 3'd7;

   // jump conditions
   typedef logic [2:0] cond_type;
   localparam cond_type COND_ALWAYS    = 3'd0;
   localparam cond_type COND_REQ       = 3'd1;
   localparam cond_type COND_START     = 3'd2;
   localparam cond_type COND_SQ_DONE   = 3'd3;
   localparam cond_type COND_TL_ZERO   = 3'd4;
   localparam cond_type COND_LOAD_DONE = 3'd5;
   localparam cond_type COND_OUT_FREE  = 3'd6;

   // one control word: datapath strobes, condition, taken and fall-through steps
   typedef struct packed {
      logic     take_req;
      logic     sq_init;
      logic     sq_iter;
      logic     adv;
      logic     load;
      logic     emit;
      cond_type cond;
      upc_type  target;
      upc_type  next;
   } uword_type;

   // read-only control store
   function automatic uword_type ucode_rom(input upc_type upc);
      uword_type w;
      w = '0;
      unique case (upc)
         UPC_FETCH: begin
            w.take_req = 1'b1;
            w.cond = COND_REQ;
            w.target = UPC_CHK_START;
            w.next = UPC_FETCH;
         end
         UPC_CHK_START: begin
            w.cond = COND_START;
            w.target = UPC_SQ_INIT;
            w.next = UPC_CHK_TL;
         end
         UPC_SQ_INIT: begin
            w.sq_init = 1'b1;
            w.cond = COND_ALWAYS;
            w.target = UPC_SQ_ITER;
            w.next = UPC_SQ_ITER;
         end
         UPC_SQ_ITER: begin
            w.sq_iter = 1'b1;
            w.cond = COND_SQ_DONE;
            w.target = UPC_LOAD;
            w.next = UPC_SQ_ITER;
         end
         UPC_CHK_TL: begin
            w.cond = COND_TL_ZERO;
            w.target = UPC_ADV;
            w.next = UPC_EMIT;
         end
         UPC_ADV: begin
            w.adv = 1'b1;
            w.cond = COND_ALWAYS;
            w.target = UPC_LOAD;
            w.next = UPC_LOAD;
         end
         UPC_LOAD: begin
            w.load = 1'b1;
            w.cond = COND_LOAD_DONE;
            w.target = UPC_EMIT;
            w.next = UPC_LOAD;
         end
         UPC_EMIT: begin
            w.emit = 1'b1;
            w.cond = COND_OUT_FREE;
            w.target = UPC_FETCH;
            w.next = UPC_EMIT;
         end
         default: begin
            w.cond = COND_ALWAYS;
            w.target = UPC_FETCH;
            w.next = UPC_FETCH;
         end
      endcase
      return w;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/blh_req_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// blh_req_if: tick channel into the heartbeat led driver
// One beat is one scheduler tick, with an optional pattern restart.
// ----------------------------------------------------------------------------
interface blh_req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink (input valid, input restart, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/blh_rsp_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// blh_rsp_if: result channel out of the heartbeat led driver
// One beat gives the led level and the pattern phase of one tick.
// ----------------------------------------------------------------------------
interface blh_rsp_if;
   logic       valid;
   logic       ready;
   logic       led_on;
   logic [1:0] phase;

   modport source (output valid, output led_on, output phase, input ready);
   modport sink (input valid, input led_on, input phase, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/breathing_led_heartbeat_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// breathing_led_heartbeat_top: breathing heartbeat led driver
// A microcoded sequencer steps a small datapath once per tick beat: wait,
// rising pwm ramp, hold and falling ramp, with the ramp length found by a
// bit-serial square root on the first tick after reset or restart.
// ----------------------------------------------------------------------------
// a plain tick passes the start check, the tick count check and the emit step;
//   a segment end adds an advance and 1 to 5 load steps, one per segment tried
// first tick after reset or restart: the ramp length is found first, by the 7
//   square root iterations of the shared 8x8 multiplier
// one tick in flight at a time; the emit step waits while the output stalls
// reset: synchronous, ramp unset, wait phase, registers back to 2000 and 1000
// ----------------------------------------------------------------------------
module breathing_led_heartbeat_top
   import blh_pkg::*;
#(
   parameter int TICK_WIDTH = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   blh_req_if.sink                    req_chan,
   blh_rsp_if.source                  rsp_chan,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);

   localparam int LEN_W = (TICK_WIDTH > 16) ? TICK_WIDTH : 16;
   localparam logic [LEN_W-1:0] TICK_MAX = LEN_W'((64'd1 << TICK_WIDTH) - 64'd1);
   localparam logic [2:0] SQ_TOP_BIT = 3'd6;
   localparam logic [2:0] MAX_SKIPS = 3'd4;

   // csr registers
   logic [15:0] beat_ff, beat_in;
   logic [15:0] tps_ff, tps_in;
   logic        csr_write;

   // sequencer
   upc_type   upc_ff, upc_in;
   uword_type uw;
   logic      cond_hit;

   // pattern state
   logic [7:0]            ramp_len_ff, ramp_len_in;
   logic                  ramp_ready_ff, ramp_ready_in;
   phase_type             phase_ff, phase_in;
   logic [7:0]            step_ff, step_in;
   logic                  on_ff, on_in;
   logic [TICK_WIDTH-1:0] tl_ff, tl_in;
   logic [2:0]            sq_bit_ff, sq_bit_in;
   logic [2:0]            skips_ff, skips_in;
   logic                  restart_ff, restart_in;

   // result register
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_led_ff, rsp_led_in;
   phase_type rsp_phase_ff, rsp_phase_in;

   // datapath values
   logic [7:0]            sq_cand;
   logic [15:0]           sq_prod;
   logic [15:0]           quarter;
   logic [15:0]           seg_raw;
   logic [LEN_W-1:0]      seg_wide;
   logic [TICK_WIDTH-1:0] seg_len;
   logic                  seg_zero;
   logic                  ramps;
   phase_type             adv_phase;
   logic [7:0]            adv_step;
   logic                  adv_on;
   logic                  req_fire;
   logic                  out_free;
   logic                  lit;

   // csr write and read
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      beat_in = beat_ff;
      tps_in  = tps_ff;
      if (csr_write) begin
         if (csr_paddr[2] == REG_BEAT_TICKS) begin
            beat_in = csr_pwdata[15:0];
         end else begin
            tps_in = csr_pwdata[15:0];
         end
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_TICKS_PER_S) ? {16'd0, tps_ff} : {16'd0, beat_ff};

   // control word fetch and handshake
   assign uw             = ucode_rom(upc_ff);
   assign req_chan.ready = uw.take_req;
   assign req_fire       = req_chan.valid && uw.take_req;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   // square root candidate: one bit per step, one 8x8 product
   assign quarter = {2'd0, beat_ff[15:2]};
   assign sq_cand = ramp_len_ff | (8'd1 << sq_bit_ff);
   assign sq_prod = sq_cand * sq_cand;

   // length of the current segment, saturated to the tick counter
   always_comb begin
      unique case (phase_ff)
         PHASE_WAIT: seg_raw = tps_ff;
         PHASE_RISE: seg_raw = {8'd0, on_ff ? step_ff : (ramp_len_ff - step_ff)};
         PHASE_HOLD: seg_raw = quarter;
         PHASE_FALL: seg_raw = {8'd0, on_ff ? (ramp_len_ff - step_ff) : step_ff};
         default:    seg_raw = tps_ff;
      endcase
   end

   assign seg_wide = LEN_W'(seg_raw);
   assign seg_len  = (seg_wide > TICK_MAX) ? TICK_MAX[TICK_WIDTH-1:0]
                                           : seg_wide[TICK_WIDTH-1:0];
   assign seg_zero = (seg_len == '0);

   // next segment of the pattern
   assign ramps = (ramp_len_ff >= 8'd2);

   always_comb begin
      adv_phase = phase_ff;
      adv_step  = 8'd1;
      adv_on    = 1'b0;
      unique case (phase_ff)
         PHASE_WAIT: adv_phase = ramps ? PHASE_RISE : PHASE_HOLD;
         PHASE_HOLD: adv_phase = ramps ? PHASE_FALL : PHASE_WAIT;
         default: begin
            if (!on_ff) begin
               adv_step = step_ff;
               adv_on   = 1'b1;
            end else if (({1'b0, step_ff} + 9'd1) < {1'b0, ramp_len_ff}) begin
               adv_step = step_ff + 8'd1;
            end else begin
               adv_phase = (phase_ff == PHASE_RISE) ? PHASE_HOLD : PHASE_WAIT;
            end
         end
      endcase
   end

   assign lit = (phase_ff == PHASE_HOLD) ||
                (((phase_ff == PHASE_RISE) || (phase_ff == PHASE_FALL)) && on_ff);

   // jump condition
   always_comb begin
      unique case (uw.cond)
         COND_ALWAYS:    cond_hit = 1'b1;
         COND_REQ:       cond_hit = req_fire;
         COND_START:     cond_hit = restart_ff || !ramp_ready_ff;
         COND_SQ_DONE:   cond_hit = (sq_bit_ff == 3'd0);
         COND_TL_ZERO:   cond_hit = (tl_ff == '0);
         COND_LOAD_DONE: cond_hit = !seg_zero || (skips_ff == MAX_SKIPS);
         COND_OUT_FREE:  cond_hit = out_free;
         default:        cond_hit = 1'b1;
      endcase
   end

   assign upc_in = cond_hit ? uw.target : uw.next;

   // datapath driven by the control word
   always_comb begin
      ramp_len_in   = ramp_len_ff;
      ramp_ready_in = ramp_ready_ff;
      phase_in      = phase_ff;
      step_in       = step_ff;
      on_in         = on_ff;
      tl_in         = tl_ff;
      sq_bit_in     = sq_bit_ff;
      skips_in      = skips_ff;
      restart_in    = restart_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_led_in    = rsp_led_ff;
      rsp_phase_in  = rsp_phase_ff;

      if (req_fire) begin
         restart_in = req_chan.restart;
      end

      // start of the square root and of the pattern
      if (uw.sq_init) begin
         ramp_len_in   = 8'd0;
         ramp_ready_in = 1'b1;
         phase_in      = PHASE_WAIT;
         step_in       = 8'd1;
         on_in         = 1'b0;
         sq_bit_in     = SQ_TOP_BIT;
         skips_in      = 3'd0;
      end

      // keep the candidate bit while its square stays below the quarter beat
      if (uw.sq_iter) begin
         if (sq_prod < quarter) begin
            ramp_len_in = sq_cand;
         end
         sq_bit_in = sq_bit_ff - 3'd1;
      end

      if (uw.adv) begin
         phase_in = adv_phase;
         step_in  = adv_step;
         on_in    = adv_on;
         skips_in = 3'd0;
      end

      // load the segment, skip empty ones, fall back to wait when all are empty
      if (uw.load) begin
         tl_in = seg_len;
         if (seg_zero) begin
            if (skips_ff == MAX_SKIPS) begin
               phase_in = PHASE_WAIT;
               step_in  = 8'd1;
               on_in    = 1'b0;
            end else begin
               phase_in = adv_phase;
               step_in  = adv_step;
               on_in    = adv_on;
               skips_in = skips_ff + 3'd1;
            end
         end
      end

      // result beat and tick count
      if (uw.emit && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_led_in   = lit;
         rsp_phase_in = phase_ff;
         if (tl_ff != '0) begin
            tl_in = tl_ff - TICK_WIDTH'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff       <= BEAT_TICKS_RESET;
         tps_ff        <= TICKS_PER_S_RESET;
         upc_ff        <= UPC_FETCH;
         ramp_len_ff   <= 8'd0;
         ramp_ready_ff <= 1'b0;
         phase_ff      <= PHASE_WAIT;
         step_ff       <= 8'd1;
         on_ff         <= 1'b0;
         tl_ff         <= '0;
         sq_bit_ff     <= 3'd0;
         skips_ff      <= 3'd0;
         restart_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         beat_ff       <= beat_in;
         tps_ff        <= tps_in;
         upc_ff        <= upc_in;
         ramp_len_ff   <= ramp_len_in;
         ramp_ready_ff <= ramp_ready_in;
         phase_ff      <= phase_in;
         step_ff       <= step_in;
         on_ff         <= on_in;
         tl_ff         <= tl_in;
         sq_bit_ff     <= sq_bit_in;
         skips_ff      <= skips_in;
         restart_ff    <= restart_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      rsp_led_ff   <= rsp_led_in;
      rsp_phase_ff <= rsp_phase_in;
   end

   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.led_on = rsp_led_ff;
   assign rsp_chan.phase  = rsp_phase_ff;

   // checks
   a_accept_dispatch: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (upc_ff == UPC_CHK_START))
      else $error("accepted tick did not reach dispatch");

   a_ramp_len_range: assert property (@(posedge clock) disable iff (reset)
      ramp_len_ff <= 8'd127)
      else $error("ramp length out of range");

   a_ramp_phase_len: assert property (@(posedge clock) disable iff (reset)
      (upc_ff == UPC_FETCH) && ((phase_ff == PHASE_RISE) || (phase_ff == PHASE_FALL))
      |-> (ramp_len_ff >= 8'd2) && (step_ff < ramp_len_ff) && (step_ff != 8'd0))
      else $error("ramp phase with bad step index");

   a_emit_holds_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_chan.ready |=> rsp_valid_ff && (upc_ff != UPC_FETCH ||
      $stable(rsp_phase_ff)))
      else $error("pending result overwritten");

endmodule
`default_nettype wire

// ===== tb/heartbeat_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// heartbeat_checker: scoreboard for the heartbeat led driver
// Follows csr writes, predicts the led level and phase of every accepted tick
// beat, compares each result beat with the oldest prediction and checks
// register readback.
// ----------------------------------------------------------------------------
module heartbeat_checker
   import blh_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   blh_req_if                         req_mon,
   blh_rsp_if                         rsp_mon,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   input  wire logic [31:0]           csr_prdata,
   input  wire logic                  csr_pready,
   output int                         fail_count,
   output int                         outstanding,
   output logic [3:0]                 phases_seen
);

   typedef struct packed {
      logic      led_on;
      phase_type phase;
   } led_state_type;

   // register copies
   logic [15:0] cfg_beat;
   logic [15:0] cfg_second;

   // pattern state
   logic [7:0]  ramp_n;
   logic        ramp_set;
   phase_type   phase_now;
   logic [7:0]  step_i;
   logic        lit_half;
   logic [15:0] seg_left;

   // predicted led states, oldest first
   led_state_type led_due[$];

   // length of the current segment, saturated to the tick counter
   function automatic logic [15:0] segment_ticks();
      int unsigned span;
      case (phase_now)
         PHASE_WAIT: span = 32'(cfg_second);
         PHASE_RISE: span = lit_half ? 32'(step_i) : 32'(ramp_n) - 32'(step_i);
         PHASE_HOLD: span = 32'(cfg_beat) >> 2;
         default:    span = lit_half ? 32'(ramp_n) - 32'(step_i) : 32'(step_i);
      endcase
      return (span > 32'hFFFF) ? 16'hFFFF : span[15:0];
   endfunction

   // move to the next segment of the pattern
   function automatic void next_segment();
      logic ramps;
      ramps = (ramp_n >= 8'd2);
      case (phase_now)
         PHASE_WAIT: begin
            phase_now = ramps ? PHASE_RISE : PHASE_HOLD;
            step_i    = 8'd1;
            lit_half  = 1'b0;
         end
         PHASE_HOLD: begin
            phase_now = ramps ? PHASE_FALL : PHASE_WAIT;
            step_i    = 8'd1;
            lit_half  = 1'b0;
         end
         default: begin
            if (!lit_half) begin
               lit_half = 1'b1;
            end else if (32'(step_i) + 1 < 32'(ramp_n)) begin
               step_i   = step_i + 8'd1;
               lit_half = 1'b0;
            end else begin
               phase_now = (phase_now == PHASE_RISE) ? PHASE_HOLD : PHASE_WAIT;
               step_i    = 8'd1;
               lit_half  = 1'b0;
            end
         end
      endcase
   endfunction

   // load the segment counter, skipping empty segments
   function automatic void start_segment();
      seg_left = segment_ticks();
      for (int k = 0; k < 4 && seg_left == 16'd0; k++) begin
         next_segment();
         seg_left = segment_ticks();
      end
      // nothing to run anywhere: park in wait
      if (seg_left == 16'd0) begin
         phase_now = PHASE_WAIT;
         step_i    = 8'd1;
         lit_half  = 1'b0;
      end
   endfunction

   // one tick of the heartbeat pattern
   function automatic led_state_type heartbeat_step(input logic restart_bit);
      int unsigned   quarter;
      int unsigned   root;
      led_state_type r;
      if (restart_bit || !ramp_set) begin
         // ramp length: largest n with n*n below a quarter beat
         quarter = 32'(cfg_beat) >> 2;
         root    = 0;
         while ((root + 1) * (root + 1) < quarter) root++;
         ramp_n    = root[7:0];
         ramp_set  = 1'b1;
         phase_now = PHASE_WAIT;
         step_i    = 8'd1;
         lit_half  = 1'b0;
         start_segment();
      end else if (seg_left == 16'd0) begin
         next_segment();
         start_segment();
      end
      r.phase  = phase_now;
      r.led_on = (phase_now == PHASE_HOLD) || ((phase_now != PHASE_WAIT) && lit_half);
      if (seg_left != 16'd0) seg_left = seg_left - 16'd1;
      return r;
   endfunction

   // watch the csr port and both channels
   always @(posedge clock) begin : watch
      led_state_type want;
      logic [31:0]   reg_want;
      if (reset) begin
         cfg_beat    = BEAT_TICKS_RESET;
         cfg_second  = TICKS_PER_S_RESET;
         ramp_n      = 8'd0;
         ramp_set    = 1'b0;
         phase_now   = PHASE_WAIT;
         step_i      = 8'd1;
         lit_half    = 1'b0;
         seg_left    = 16'd0;
         fail_count  = 0;
         phases_seen = 4'b0000;
         led_due.delete();
      end else begin
         // register writes and readback
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               if (csr_paddr[2] == REG_BEAT_TICKS) cfg_beat = csr_pwdata[15:0];
               else cfg_second = csr_pwdata[15:0];
            end else begin
               reg_want = {16'd0, (csr_paddr[2] == REG_BEAT_TICKS) ? cfg_beat : cfg_second};
               if (csr_prdata !== reg_want) begin
                  fail_count++;
                  $display("%0t: csr read at %0d: expected %h, got %h",
                           $time, csr_paddr, reg_want, csr_prdata);
               end
            end
         end
         // result beats against the oldest prediction
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (led_due.size() == 0) begin
               fail_count++;
               $display("%0t: result beat: expected none, got led_on %b phase %0d",
                        $time, rsp_mon.led_on, rsp_mon.phase);
            end else begin
               want = led_due.pop_front();
               if (rsp_mon.phase !== want.phase) begin
                  fail_count++;
                  $display("%0t: phase: expected %0d, got %0d",
                           $time, want.phase, rsp_mon.phase);
               end
               if (rsp_mon.led_on !== want.led_on) begin
                  fail_count++;
                  $display("%0t: led_on: expected %b, got %b",
                           $time, want.led_on, rsp_mon.led_on);
               end
               phases_seen[want.phase] = 1'b1;
            end
         end
         // tick beats
         if (req_mon.valid && req_mon.ready) led_due.push_back(heartbeat_step(req_mon.restart));
      end
      outstanding <= led_due.size();
   end

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// testbench: top of the heartbeat led driver test
// Drives tick beats and csr settings, stalls both channels at random and
// gives the verdict from the failure count of the checker.
// ----------------------------------------------------------------------------
module testbench;
   import blh_pkg::*;

   localparam int TOTAL_TICKS = 1150;
   localparam int TAIL_TICKS  = 150;
   localparam int LONG_HOLD   = 200;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic [CSR_ADDR_W-1:0] ADDR_BEAT   = {REG_BEAT_TICKS, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] ADDR_SECOND = {REG_TICKS_PER_S, 2'b00};

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0]           csr_pwdata;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   int         fail_count;
   int         outstanding;
   logic [3:0] phases_seen;
   int         cycle_count;
   int         ticks_sent;
   int         restarts_sent;
   int         settings_done;
   logic       quiet_tail;
   logic       tx_calm;
   int         hold_seq;

   // receiver state
   int         hold_seen;
   int         hold_left;
   int         stall_left;
   int         calm_left;
   logic       rx_calm;

   blh_req_if tick_bus ();
   blh_rsp_if led_bus ();

   breathing_led_heartbeat_top #(.TICK_WIDTH(16)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (tick_bus),
      .rsp_chan    (led_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   heartbeat_checker scoreboard (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (tick_bus),
      .rsp_mon     (led_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .fail_count  (fail_count),
      .outstanding (outstanding),
      .phases_seen (phases_seen)
   );

   // clock
   always #6 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d result beats outstanding", $time, outstanding);
         $display("CHECK FAILED");
         $finish;
      end
   end

   // result side: random stall bursts, calm stretches and one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         led_bus.ready <= 1'b0;
      end else begin
         if (hold_seen != hold_seq) begin
            hold_seen = hold_seq;
            hold_left = LONG_HOLD;
         end
         if (calm_left > 0) begin
            calm_left--;
         end else begin
            calm_left = $urandom_range(20, 120);
            rx_calm   = ($urandom_range(0, 3) == 0);
         end
         if (hold_left > 0) begin
            hold_left--;
            led_bus.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            led_bus.ready <= 1'b0;
         end else if (!quiet_tail && !rx_calm && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 5);
            led_bus.ready <= 1'b0;
         end else begin
            led_bus.ready <= 1'b1;
         end
      end
   end

   // offer one tick beat until taken, then maybe idle a burst
   task automatic send_tick(input logic restart_bit);
      tick_bus.valid   <= 1'b1;
      tick_bus.restart <= restart_bit;
      do @(posedge clock); while (!tick_bus.ready);
      ticks_sent++;
      if (restart_bit) restarts_sent++;
      if (!quiet_tail && !tx_calm && $urandom_range(0, 4) == 0) begin
         tick_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // stop offering and wait for every predicted result
   task automatic drain();
      tick_bus.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // one csr transfer: setup, access, then idle
   task automatic csr_access(input logic write_en, input logic [CSR_ADDR_W-1:0] addr,
                             input logic [15:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write_en;
      csr_paddr   <= addr;
      csr_pwdata  <= {16'($urandom), value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // new register setting once the block is idle, with readback
   task automatic configure(input logic [15:0] beat_len, input logic [15:0] second_len);
      drain();
      csr_access(1'b1, ADDR_BEAT, beat_len);
      csr_access(1'b1, ADDR_SECOND, second_len);
      csr_access(1'b0, ADDR_BEAT, 16'd0);
      csr_access(1'b0, ADDR_SECOND, 16'd0);
      settings_done++;
   endtask

   initial begin : stimulus
      logic [15:0] beat_len;
      logic [15:0] second_len;
      int          span;
      int          phase_no;
      clock            = 1'b0;
      reset            = 1'b1;
      tick_bus.valid   = 1'b0;
      tick_bus.restart = 1'b0;
      led_bus.ready    = 1'b0;
      csr_psel         = 1'b0;
      csr_penable      = 1'b0;
      csr_pwrite       = 1'b0;
      csr_paddr        = '0;
      csr_pwdata       = '0;
      cycle_count      = 0;
      ticks_sent       = 0;
      restarts_sent    = 0;
      settings_done    = 0;
      quiet_tail       = 1'b0;
      tx_calm          = 1'b0;
      hold_seq         = 0;
      hold_seen        = 0;
      hold_left        = 0;
      stall_left       = 0;
      calm_left        = 0;
      rx_calm          = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: first tick sizes the ramp, then the long wait
      send_tick(1'b0);
      send_tick(1'b0);
      // every segment empty: stays in wait with the led off
      configure(16'd0, 16'd0);
      send_tick(1'b0);
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b0);
      // ramp too short to run: wait and hold only
      configure(16'd16, 16'd2);
      send_tick(1'b1);
      repeat (5) send_tick(1'b0);
      // shortest ramp that runs
      configure(16'd36, 16'd1);
      send_tick(1'b1);
      repeat (5) send_tick(1'b0);
      // widest beat, no wait: straight into the longest ramp
      configure(16'hFFFF, 16'd0);
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b0);
      // new registers without restart keep the old ramp length
      configure(16'd8, 16'hFFFF);
      send_tick(1'b0);
      send_tick(1'b0);

      // random settings, each run mostly as a clean pattern from a restart
      phase_no = 0;
      while (ticks_sent < TOTAL_TICKS) begin
         case ($urandom_range(0, 9))
            0: begin
               beat_len   = 16'($urandom);
               second_len = 16'($urandom_range(1, 65535));
            end
            1: begin
               beat_len   = 16'hFFFF;
               second_len = 16'($urandom_range(1, 8));
            end
            2: begin
               beat_len   = 16'($urandom_range(0, 7));
               second_len = 16'($urandom_range(1, 4));
            end
            default: begin
               beat_len   = 16'($urandom_range(8, 320));
               second_len = 16'($urandom_range(1, 24));
            end
         endcase
         configure(beat_len, second_len);
         tx_calm = ($urandom_range(0, 3) == 0);
         span    = $urandom_range(60, 140);
         send_tick($urandom_range(0, 7) != 0);
         for (int j = 1; j < span; j++) begin
            if (ticks_sent >= TOTAL_TICKS - TAIL_TICKS) begin
               quiet_tail <= 1'b1;
               tx_calm = 1'b1;
            end
            // long receiver hold-off while ticks keep coming
            if (phase_no == 2 && j == 20) hold_seq <= hold_seq + 1;
            // sender pause until the pipeline is empty
            if (phase_no == 3 && j == span / 2) drain();
            send_tick($urandom_range(0, 39) == 0);
         end
         phase_no++;
      end

      drain();
      repeat (20) @(posedge clock);
      $display("covered %0d ticks (%0d restarts) over %0d register settings",
               ticks_sent, restarts_sent, settings_done);
      $display("phases seen in results (fall..wait): %b", phases_seen);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
`default_nettype wire

// ===== breathing_led_heartbeat_top.f =====
rtl/core/blh_pkg.sv
rtl/core/blh_req_if.sv
rtl/core/blh_rsp_if.sv
rtl/core/breathing_led_heartbeat_top.sv
tb/heartbeat_checker.sv
tb/testbench.sv
